FILE: rtl/core/kvt_pkg.sv
package kvt_pkg;

  localparam int unsigned OFFSET_BITS = 16;
  localparam int unsigned OUT_BITS    = 16;

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [OUT_BITS-1:0]    out_offset_t;

  localparam logic [3:0] PH_IDLE         = 4'd0;
  localparam logic [3:0] PH_KEY          = 4'd1;
  localparam logic [3:0] PH_AFTER_KEY    = 4'd2;
  localparam logic [3:0] PH_BEFORE_VALUE = 4'd3;
  localparam logic [3:0] PH_BARE         = 4'd4;
  localparam logic [3:0] PH_CLOSED       = 4'd5;
  localparam logic [3:0] PH_AFTER_VALUE  = 4'd6;
  localparam logic [3:0] PH_ERROR        = 4'd7;

  typedef enum logic [1:0] {
    CK_NONE  = 2'd0,
    CK_QUOTE = 2'd1,
    CK_BRACE = 2'd2
  } closing_e;

  typedef enum logic [2:0] {
    ST_PAIR      = 3'd0,
    ST_END       = 3'd1,
    ST_COLON     = 3'd2,
    ST_CONTROL   = 3'd3,
    ST_UNEXP_END = 3'd4,
    ST_CLOSING   = 3'd5,
    ST_LONG      = 3'd6
  } status_e;

  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  typedef struct packed {
    status_e     status;
    out_offset_t key_start;
    out_offset_t key_stop;
    out_offset_t value_start;
    out_offset_t value_stop;
    logic        last_of_run;
  } result_t;

  function automatic logic is_space(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic logic is_control(logic [7:0] c);
    return c == CH_COLON || c == CH_QUOTE || c == CH_LBRACE || c == CH_RBRACE ||
           c == CH_COMMA;
  endfunction

  function automatic out_offset_t to_out(offset_t v);
    logic [OFFSET_BITS+OUT_BITS-1:0] wide;
    wide = {{OUT_BITS{1'b0}}, v};
    return wide[OUT_BITS-1:0];
  endfunction

endpackage

FILE: rtl/core/kvt_parse.sv
module kvt_parse (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  logic [7:0]       text_byte_i,
  input  logic             end_of_text_i,
  output logic [1:0]       count_o,
  output kvt_pkg::result_t res0_o,
  output kvt_pkg::result_t res1_o
);
  import kvt_pkg::*;

  logic [3:0] phase_q, phase_d;
  offset_t    off_q, off_d;
  offset_t    ks_q, ks_d;
  offset_t    ke_q, ke_d;
  offset_t    vs_q, vs_d;
  closing_e   ck_q, ck_d;
  logic [7:0] c;

  assign c = text_byte_i;

  always_comb begin
    phase_d = phase_q;
    off_d   = off_q;
    ks_d    = ks_q;
    ke_d    = ke_q;
    vs_d    = vs_q;
    ck_d    = ck_q;
    count_o = 2'd0;
    res0_o  = '{status: ST_END, key_start: '0, key_stop: '0, value_start: '0,
                value_stop: '0, last_of_run: 1'b1};
    res1_o  = res0_o;
    if (end_of_text_i) begin
      count_o = 2'd1;
      case (phase_q)
        PH_IDLE, PH_AFTER_VALUE: res0_o.status = ST_END;
        PH_KEY, PH_AFTER_KEY:    res0_o.status = ST_COLON;
        PH_BEFORE_VALUE:         res0_o.status = ST_UNEXP_END;
        PH_CLOSED:               res0_o.status = ST_CLOSING;
        PH_BARE: begin
          count_o = 2'd2;
          res0_o  = '{status: ST_PAIR, key_start: to_out(ks_q), key_stop: to_out(ke_q),
                      value_start: to_out(vs_q), value_stop: to_out(off_q),
                      last_of_run: 1'b0};
        end
        default: count_o = 2'd0;
      endcase
      phase_d = PH_IDLE;
      off_d   = '0;
      ck_d    = CK_NONE;
    end else if (phase_q != PH_ERROR) begin
      if (&off_q) begin
        count_o       = 2'd1;
        res0_o.status = ST_LONG;
        phase_d       = PH_ERROR;
      end else begin
        case (phase_q)
          PH_IDLE, PH_AFTER_VALUE: begin
            if (phase_q == PH_AFTER_VALUE && c == CH_COMMA) begin
              phase_d = PH_IDLE;
            end else if (!is_space(c)) begin
              ks_d = off_q;
              if (is_control(c)) begin
                ke_d = off_q;
                if (c == CH_COLON) begin
                  phase_d = PH_BEFORE_VALUE;
                end else begin
                  count_o       = 2'd1;
                  res0_o.status = ST_COLON;
                  phase_d       = PH_ERROR;
                end
              end else begin
                phase_d = PH_KEY;
              end
            end
          end
          PH_KEY: begin
            if (is_space(c)) begin
              ke_d    = off_q;
              phase_d = PH_AFTER_KEY;
            end else if (is_control(c)) begin
              ke_d = off_q;
              if (c == CH_COLON) begin
                phase_d = PH_BEFORE_VALUE;
              end else begin
                count_o       = 2'd1;
                res0_o.status = ST_COLON;
                phase_d       = PH_ERROR;
              end
            end
          end
          PH_AFTER_KEY: begin
            if (c == CH_COLON) begin
              phase_d = PH_BEFORE_VALUE;
            end else if (!is_space(c)) begin
              count_o       = 2'd1;
              res0_o.status = ST_COLON;
              phase_d       = PH_ERROR;
            end
          end
          PH_BEFORE_VALUE: begin
            if (is_space(c)) begin
              phase_d = phase_q;
            end else if (c == CH_QUOTE || c == CH_LBRACE) begin
              ck_d    = (c == CH_QUOTE) ? CK_QUOTE : CK_BRACE;
              vs_d    = off_q + offset_t'(1);
              phase_d = PH_CLOSED;
            end else if (c == CH_COLON || c == CH_RBRACE || c == CH_COMMA) begin
              count_o       = 2'd1;
              res0_o.status = ST_CONTROL;
              phase_d       = PH_ERROR;
            end else begin
              ck_d    = CK_NONE;
              vs_d    = off_q;
              phase_d = PH_BARE;
            end
          end
          PH_BARE: begin
            if (c == CH_COMMA) begin
              count_o = 2'd1;
              res0_o  = '{status: ST_PAIR, key_start: to_out(ks_q),
                          key_stop: to_out(ke_q), value_start: to_out(vs_q),
                          value_stop: to_out(off_q), last_of_run: 1'b1};
              phase_d = PH_IDLE;
            end
          end
          PH_CLOSED: begin
            if ((ck_q == CK_QUOTE && c == CH_QUOTE) ||
                (ck_q != CK_QUOTE && c == CH_RBRACE)) begin
              count_o = 2'd1;
              res0_o  = '{status: ST_PAIR, key_start: to_out(ks_q),
                          key_stop: to_out(ke_q), value_start: to_out(vs_q),
                          value_stop: to_out(off_q), last_of_run: 1'b1};
              ck_d    = CK_NONE;
              phase_d = PH_AFTER_VALUE;
            end
          end
          default: phase_d = PH_ERROR;
        endcase
        if (phase_d != PH_ERROR) begin
          off_d = off_q + offset_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      off_q   <= '0;
      ks_q    <= '0;
      ke_q    <= '0;
      vs_q    <= '0;
      ck_q    <= CK_NONE;
    end else if (go_i) begin
      phase_q <= phase_d;
      off_q   <= off_d;
      ks_q    <= ks_d;
      ke_q    <= ke_d;
      vs_q    <= vs_d;
      ck_q    <= ck_d;
    end
  end

endmodule

FILE: rtl/core/kvt_outq.sv
module kvt_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [1:0]       push_cnt_i,
  input  kvt_pkg::result_t push0_i,
  input  kvt_pkg::result_t push1_i,
  output logic             fits_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output kvt_pkg::result_t head_o
);
  import kvt_pkg::*;

  result_t    ent_q [2];
  result_t    ent_d [2];
  logic [1:0] cnt_q, cnt_d, left;
  logic       pop;

  assign out_valid_o = cnt_q != 2'd0;
  assign head_o      = ent_q[0];
  assign pop         = out_valid_o && out_ready_i;
  assign left        = cnt_q - {1'b0, pop};
  assign fits_o      = ({1'b0, left} + {1'b0, push_cnt_i}) <= 3'd2;

  always_comb begin
    ent_d[0] = pop ? ent_q[1] : ent_q[0];
    ent_d[1] = ent_q[1];
    if (left == 2'd0) begin
      ent_d[0] = push0_i;
      ent_d[1] = push1_i;
    end else if (left == 2'd1) begin
      ent_d[1] = push0_i;
    end
    cnt_d = left + (push_i ? push_cnt_i : 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

FILE: rtl/core/key_value_text_tokenizer.sv
// Key/value tokenizer: takes one text byte per item (end_of_text_i marks the
// terminator) and reports each key:value pair with its byte offsets, the normal
// end and each error kind. An item is registered on input and then parsed into
// a two-entry result queue, so one byte per cycle is taken while the output is
// drained every cycle; a result reaches the output through the input register
// and the queue. An end marker that closes a bare value gives two results, which
// the queue takes at once; the input stalls only when the output is held off and
// the queue has no room for the next item's results.
module key_value_text_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [15:0] key_start_o,
  output logic [15:0] key_stop_o,
  output logic [15:0] value_start_o,
  output logic [15:0] value_stop_o,
  output logic        last_of_run_o
);
  import kvt_pkg::*;

  logic       hold_valid_q;
  logic [7:0] hold_byte_q;
  logic       hold_eot_q;
  logic       go, fits;
  logic [1:0] cnt;
  result_t    res0, res1, head;

  assign go         = hold_valid_q && fits;
  assign in_ready_o = !hold_valid_q || go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      hold_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      hold_byte_q <= text_byte_i;
      hold_eot_q  <= end_of_text_i;
    end
  end

  kvt_parse u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .go_i          (go),
    .text_byte_i   (hold_byte_q),
    .end_of_text_i (hold_eot_q),
    .count_o       (cnt),
    .res0_o        (res0),
    .res1_o        (res1)
  );

  kvt_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (go),
    .push_cnt_i  (cnt),
    .push0_i     (res0),
    .push1_i     (res1),
    .fits_o      (fits),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign status_o      = head.status;
  assign key_start_o   = head.key_start;
  assign key_stop_o    = head.key_stop;
  assign value_start_o = head.value_start;
  assign value_stop_o  = head.value_stop;
  assign last_of_run_o = head.last_of_run;

endmodule

FILE: rtl/core/kvt_checker.sv
module kvt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  status_i,
  input logic [15:0] key_start_i,
  input logic [15:0] key_stop_i,
  input logic [15:0] value_start_i,
  input logic [15:0] value_stop_i,
  input logic        last_of_run_i
);
  import kvt_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i))
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_PAIR |->
      key_start_i == '0 && key_stop_i == '0 && value_start_i == '0 &&
      value_stop_i == '0)
    else $error("offsets not cleared on status result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_PAIR |-> last_of_run_i)
    else $error("status result not last of run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_PAIR |->
      key_start_i <= key_stop_i && key_stop_i <= value_stop_i)
    else $error("pair offsets out of order");

endmodule

bind key_value_text_tokenizer kvt_checker u_kvt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_i      (status_o),
  .key_start_i   (key_start_o),
  .key_stop_i    (key_stop_o),
  .value_start_i (value_start_o),
  .value_stop_i  (value_stop_o),
  .last_of_run_i (last_of_run_o)
);

FILE: test/kvt_checker.sv
module kvt_tb_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  status_i,
  input  logic [15:0] key_start_i,
  input  logic [15:0] key_stop_i,
  input  logic [15:0] value_start_i,
  input  logic [15:0] value_stop_i,
  input  logic        last_of_run_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import kvt_pkg::*;

  logic [3:0] phase_q;
  offset_t    offset_q;
  offset_t    key_start_q;
  offset_t    key_stop_q;
  offset_t    value_start_q;
  closing_e   closing_q;
  result_t    expected_q[$];
  int         fails;

  function automatic logic is_blank(logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0B, 8'h0A, 8'h0D};
  endfunction

  function automatic logic is_mark(logic [7:0] c);
    return c inside {CH_COLON, CH_QUOTE, CH_LBRACE, CH_RBRACE, CH_COMMA};
  endfunction

  function automatic void raise_status(status_e s);
    result_t r;
    r             = '0;
    r.status      = s;
    r.last_of_run = 1'b1;
    expected_q.push_back(r);
    phase_q = PH_ERROR;
  endfunction

  function automatic void push_pair(offset_t stop, logic last);
    result_t r;
    r.status      = ST_PAIR;
    r.key_start   = out_offset_t'(key_start_q);
    r.key_stop    = out_offset_t'(key_stop_q);
    r.value_start = out_offset_t'(value_start_q);
    r.value_stop  = out_offset_t'(stop);
    r.last_of_run = last;
    expected_q.push_back(r);
  endfunction

  function automatic void start_key(logic [7:0] c);
    if (is_blank(c)) return;
    key_start_q = offset_q;
    if (is_mark(c)) begin
      key_stop_q = offset_q;
      if (c == CH_COLON) phase_q = PH_BEFORE_VALUE;
      else raise_status(ST_COLON);
    end else begin
      phase_q = PH_KEY;
    end
  endfunction

  function automatic void predict_results(logic [7:0] c, logic eot);
    if (eot) begin
      case (phase_q)
        PH_IDLE, PH_AFTER_VALUE: raise_status(ST_END);
        PH_KEY, PH_AFTER_KEY:    raise_status(ST_COLON);
        PH_BEFORE_VALUE:         raise_status(ST_UNEXP_END);
        PH_CLOSED:               raise_status(ST_CLOSING);
        PH_BARE: begin
          push_pair(offset_q, 1'b0);
          raise_status(ST_END);
        end
        default: ;
      endcase
      phase_q   = PH_IDLE;
      offset_q  = '0;
      closing_q = CK_NONE;
      return;
    end
    if (phase_q == PH_ERROR) return;
    if (offset_q == '1) begin
      raise_status(ST_LONG);
      return;
    end
    case (phase_q)
      PH_IDLE: start_key(c);
      PH_KEY: begin
        if (is_blank(c)) begin
          key_stop_q = offset_q;
          phase_q    = PH_AFTER_KEY;
        end else if (is_mark(c)) begin
          key_stop_q = offset_q;
          if (c == CH_COLON) phase_q = PH_BEFORE_VALUE;
          else raise_status(ST_COLON);
        end
      end
      PH_AFTER_KEY: begin
        if (c == CH_COLON) phase_q = PH_BEFORE_VALUE;
        else if (!is_blank(c)) raise_status(ST_COLON);
      end
      PH_BEFORE_VALUE: begin
        if (c == CH_QUOTE || c == CH_LBRACE) begin
          closing_q     = (c == CH_QUOTE) ? CK_QUOTE : CK_BRACE;
          value_start_q = offset_q + 1'b1;
          phase_q       = PH_CLOSED;
        end else if (c == CH_COLON || c == CH_RBRACE || c == CH_COMMA) begin
          raise_status(ST_CONTROL);
        end else if (!is_blank(c)) begin
          closing_q     = CK_NONE;
          value_start_q = offset_q;
          phase_q       = PH_BARE;
        end
      end
      PH_BARE: begin
        if (c == CH_COMMA) begin
          push_pair(offset_q, 1'b1);
          phase_q = PH_IDLE;
        end
      end
      PH_CLOSED: begin
        if ((closing_q == CK_QUOTE && c == CH_QUOTE) ||
            (closing_q != CK_QUOTE && c == CH_RBRACE)) begin
          push_pair(offset_q, 1'b1);
          closing_q = CK_NONE;
          phase_q   = PH_AFTER_VALUE;
        end
      end
      PH_AFTER_VALUE: begin
        if (c == CH_COMMA) phase_q = PH_IDLE;
        else start_key(c);
      end
      default: phase_q = PH_ERROR;
    endcase
    if (phase_q != PH_ERROR) offset_q = offset_q + 1'b1;
  endfunction

  function automatic void compare_field(string name, logic [15:0] want_v,
                                        logic [15:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      fails++;
    end
  endfunction

  function automatic void check_result();
    result_t want;
    if (expected_q.size() == 0) begin
      $error("status: expected no result, actual %0d", status_i);
      fails++;
      return;
    end
    want = expected_q.pop_front();
    compare_field("status", 16'(want.status), 16'(status_i));
    compare_field("key_start", want.key_start, key_start_i);
    compare_field("key_stop", want.key_stop, key_stop_i);
    compare_field("value_start", want.value_start, value_start_i);
    compare_field("value_stop", want.value_stop, value_stop_i);
    compare_field("last_of_run", 16'(want.last_of_run), 16'(last_of_run_i));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       = PH_IDLE;
      offset_q      = '0;
      key_start_q   = '0;
      key_stop_q    = '0;
      value_start_q = '0;
      closing_q     = CK_NONE;
      expected_q.delete();
      fails         = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) predict_results(text_byte_i, end_of_text_i);
      fail_count_o <= fails;
      pending_o    <= expected_q.size();
    end
  end

endmodule

FILE: test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kvt_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  text_byte_i;
  logic        end_of_text_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  status_o;
  logic [15:0] key_start_o;
  logic [15:0] key_stop_o;
  logic [15:0] value_start_o;
  logic [15:0] value_stop_o;
  logic        last_of_run_o;

  int         fail_count;
  int         pending;
  int         items_sent;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         cycles;
  logic [7:0] text_q[$];

  key_value_text_tokenizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .key_start_o   (key_start_o),
    .key_stop_o    (key_stop_o),
    .value_start_o (value_start_o),
    .value_stop_o  (value_stop_o),
    .last_of_run_o (last_of_run_o)
  );

  kvt_tb_checker kvt_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_i      (status_o),
    .key_start_i   (key_start_o),
    .key_stop_i    (key_stop_o),
    .value_start_i (value_start_o),
    .value_stop_i  (value_stop_o),
    .last_of_run_i (last_of_run_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int n;
    out_ready_i = 1'b0;
    @(negedge clk_i);
    forever begin
      if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        n = $urandom_range(1, 17);
        out_ready_i <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(negedge clk_i);
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eot);
    int n;
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      n = $urandom_range(1, 17);
      in_valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    text_byte_i   <= b;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_string(input string s, input logic [7:0] tail);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    send_item(tail, 1'b1);
  endtask

  // hold off until every expected item is out and the pipeline is empty
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [7:0] rand_key_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c inside {8'h20, 8'h09, 8'h0B, 8'h0A, 8'h0D,
                     CH_COLON, CH_QUOTE, CH_LBRACE, CH_RBRACE, CH_COMMA});
    return c;
  endfunction

  function automatic logic [7:0] rand_byte_except(logic [7:0] x);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == x);
    return c;
  endfunction

  function automatic logic [7:0] rand_mark();
    case ($urandom_range(0, 4))
      0:       return CH_COLON;
      1:       return CH_QUOTE;
      2:       return CH_LBRACE;
      3:       return CH_RBRACE;
      default: return CH_COMMA;
    endcase
  endfunction

  function automatic void add_blanks();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 4))
        0:       text_q.push_back(8'h20);
        1:       text_q.push_back(8'h09);
        2:       text_q.push_back(8'h0B);
        3:       text_q.push_back(8'h0A);
        default: text_q.push_back(8'h0D);
      endcase
    end
  endfunction

  function automatic void build_pairs();
    int pairs;
    int len;
    int kind;
    logic last;
    pairs = $urandom_range(1, 4);
    for (int p = 0; p < pairs; p++) begin
      last = (p == pairs - 1);
      add_blanks();
      len = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 5);
      for (int i = 0; i < len; i++) text_q.push_back(rand_key_char());
      add_blanks();
      text_q.push_back(CH_COLON);
      add_blanks();
      kind = $urandom_range(0, 2);
      len  = $urandom_range(0, 6);
      if (kind == 0) begin
        text_q.push_back(rand_key_char());
        for (int i = 0; i < len; i++) text_q.push_back(rand_byte_except(CH_COMMA));
        if (!last || $urandom_range(0, 1)) text_q.push_back(CH_COMMA);
      end else begin
        text_q.push_back(kind == 1 ? CH_QUOTE : CH_LBRACE);
        for (int i = 0; i < len; i++)
          text_q.push_back(rand_byte_except(kind == 1 ? CH_QUOTE : CH_RBRACE));
        text_q.push_back(kind == 1 ? CH_QUOTE : CH_RBRACE);
        add_blanks();
        if ($urandom_range(0, 1)) text_q.push_back(CH_COMMA);
      end
    end
    add_blanks();
  endfunction

  task automatic send_text();
    int mode;
    int pos;
    int len;
    text_q.delete();
    mode = $urandom_range(0, 99);
    if (mode < 90) begin
      build_pairs();
      pos = $urandom_range(0, text_q.size());
      if (mode >= 80) begin
        while (text_q.size() > pos) void'(text_q.pop_back());
      end else if (mode >= 75 && pos < text_q.size()) begin
        text_q[pos] = 8'($urandom_range(0, 255));
      end else if (mode >= 70) begin
        text_q.insert(pos, rand_mark());
      end
    end else begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++)
        text_q.push_back($urandom_range(0, 1) ? rand_mark() : 8'($urandom_range(0, 255)));
    end
    foreach (text_q[i]) send_item(text_q[i], 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic run_texts(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) send_text();
  endtask

  initial begin
    in_valid_i    = 1'b0;
    text_byte_i   = 8'h00;
    end_of_text_i = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    items_sent    = 0;
    rst_ni        = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    send_item(8'hFF, 1'b1);
    send_string(":", 8'h00);
    send_string("a", 8'hFF);
    send_string("a\t", 8'h00);
    send_string("a:x", 8'hFF);
    send_string("{z", 8'h00);
    send_string("b:\"q\"", 8'hFF);
    send_string("c:{},", 8'h00);
    send_string("d:,", 8'hFF);
    send_string("e:{x", 8'h00);
    send_item(8'h00, 1'b0);
    send_item(CH_COLON, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h5A, 1'b1);
    wait_drained();

    send_idle_pct = 10;
    recv_idle_pct = 10;
    run_texts(130);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 25;
    run_texts(110);
    wait_drained();
    send_idle_pct = 25;
    recv_idle_pct = 0;
    run_texts(110);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_texts(100);
    wait_drained();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
